// ===== design/dtsd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtsd_pkg: shared types and constants for the distance to servo drive block
// Holds the sequencer state type, configuration register indexes and the
// fixed field widths and pulse scaling constants.
// ----------------------------------------------------------------------------
package dtsd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DIST_W     = 10;
    localparam int VALUE_W    = 8;
    localparam int PULSE_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 3'd4;

    localparam logic [VALUE_W-1:0] MIN_VALUE_RST    = 8'd0;
    localparam logic [VALUE_W-1:0] MAX_VALUE_RST    = 8'd90;
    localparam logic [DIST_W-1:0]  MIN_DISTANCE_RST = 10'd0;
    localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST = 10'd20;

    // The pulse span of 450 over 180 degrees reduces to 5/2.
    localparam logic [PULSE_W-1:0] PULSE_LOW   = 10'd125;
    localparam logic [2:0]         PULSE_NUM   = 3'd5;
    localparam int                 PULSE_SHIFT = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_MAP_MUL,
        ST_MAP_LOAD,
        ST_MAP_DIV,
        ST_FINISH,
        ST_OUTPUT
    } state_t;

endpackage
`default_nettype wire

// ===== design/distance_to_servo_drive.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// distance_to_servo_drive: moving average, linear map and clamp to a drive
// Each item carries a distance sample and a mode bit. The block averages the
// last WINDOW_DEPTH samples, maps the mean onto the configured value range
// and produces a drive value and a servo pulse count.
//
// The input channel (s_) takes one item at a time; s_ready is high only
// while the sequencer is idle. The window mean comes from a reciprocal
// multiply, and one restoring divider then forms the map quotient, one
// quotient bit per cycle. An accepted item passes the mean, multiply,
// divider load, divide and finish states, and s_ready returns only once its
// result is loaded into the m_ channel output register. With equal distance
// bounds the divider is skipped. A stalled receiver holds the result in the
// output register, the next item may still be accepted, and its result waits
// in the sequencer until the output register frees up. Configuration is
// written through cfg_we, cfg_index and cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// A synchronous low aresetn clears the window, the sum and the sequencer.
// ----------------------------------------------------------------------------
module distance_to_servo_drive
    import dtsd_pkg::*;
#(
    parameter int WINDOW_DEPTH  = 10,
    parameter int OUTLIER_LIMIT = 800
) (
    input  wire                   aclk,
    input  wire                   aresetn,

    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_wdata,

    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire [SAMPLE_W-1:0]    s_distance_sample,
    input  wire                   s_haptic_mode,

    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [DIST_W-1:0]     m_average_distance,
    output logic [VALUE_W-1:0]    m_drive_value,
    output logic [PULSE_W-1:0]    m_servo_pulse,
    output logic                  m_is_haptic
);

    localparam int SUM_W       = DIST_W + $clog2(WINDOW_DEPTH);
    localparam int RECIP_SHIFT = SUM_W + $clog2(WINDOW_DEPTH);
    localparam int RECIP_W     = SUM_W + 2;
    localparam int AVG_PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);
    localparam int DIFF_W      = DIST_W + 1;
    localparam int SPAN_W      = VALUE_W + 1;
    localparam int PROD_W      = DIFF_W + SPAN_W;
    localparam int MAG_W       = PROD_W - 1;
    localparam int DIVIDEND_W  = MAG_W;
    localparam int DVS_W       = DIST_W;
    localparam int CNT_W       = $clog2(DIVIDEND_W + 1);
    localparam int VAL_W       = DIVIDEND_W + 2;

    state_t state_reg, state_next;

    logic [VALUE_W-1:0] min_value_reg;
    logic [VALUE_W-1:0] max_value_reg;
    logic [DIST_W-1:0]  min_distance_reg;
    logic [DIST_W-1:0]  max_distance_reg;
    logic               direction_reg;

    logic [DIST_W-1:0]  win_reg [WINDOW_DEPTH];
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [DIST_W-1:0]  sample_sel;
    logic               haptic_reg;
    logic [DIST_W-1:0]  avg_reg;
    logic [AVG_PROD_W-1:0] avg_prod;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [DIFF_W-1:0] diff_val;
    logic signed [SPAN_W-1:0] span_val;
    logic signed [DIFF_W-1:0] den_val;
    logic [PROD_W-1:0]        prod_abs;
    logic [DIFF_W-1:0]        den_abs;
    logic                     den_zero;
    logic                     neg_reg;

    logic [VALUE_W-1:0] out_lo, out_hi;

    logic [DVS_W-1:0]      div_rem_reg;
    logic [DIVIDEND_W-1:0] div_quo_reg;
    logic [DVS_W-1:0]      div_dvs_reg;
    logic [CNT_W-1:0]      div_cnt_reg;
    logic [DVS_W:0]        div_shift;
    logic [DVS_W:0]        div_diff;
    logic                  div_ge;
    logic                  div_last;

    logic signed [VAL_W-1:0] q_signed;
    logic signed [VAL_W-1:0] map_val;
    logic signed [VAL_W-1:0] lo_ext, hi_ext;
    logic [VALUE_W-1:0]      clamp_val;
    logic [VALUE_W-1:0]      drive_next;
    logic [VALUE_W-1:0]      val_reg;

    logic [PULSE_W:0]        pulse_scaled;
    logic [PULSE_W-1:0]      pulse_next;

    logic accept;
    logic load_avg;
    logic load_map_div;
    logic div_step;
    logic load_mul;
    logic load_val;
    logic load_out;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_value_reg    <= MIN_VALUE_RST;
            max_value_reg    <= MAX_VALUE_RST;
            min_distance_reg <= MIN_DISTANCE_RST;
            max_distance_reg <= MAX_DISTANCE_RST;
            direction_reg    <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MIN_VALUE:    min_value_reg    <= cfg_wdata[VALUE_W-1:0];
                CFG_MAX_VALUE:    max_value_reg    <= cfg_wdata[VALUE_W-1:0];
                CFG_MIN_DISTANCE: min_distance_reg <= cfg_wdata[DIST_W-1:0];
                CFG_MAX_DISTANCE: max_distance_reg <= cfg_wdata[DIST_W-1:0];
                CFG_DIRECTION:    direction_reg    <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG: begin
                state_next = ST_MAP_MUL;
            end
            ST_MAP_MUL: begin
                state_next = den_zero ? ST_FINISH : ST_MAP_LOAD;
            end
            ST_MAP_LOAD: begin
                state_next = ST_MAP_DIV;
            end
            ST_MAP_DIV: begin
                if (div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT: begin
                if (!m_valid || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control strobes of the sequencer.
    always_comb begin
        s_ready      = 1'b0;
        load_avg     = 1'b0;
        load_map_div = 1'b0;
        div_step     = 1'b0;
        load_mul     = 1'b0;
        load_val     = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_AVG: begin
                load_avg = 1'b1;
            end
            ST_MAP_MUL: begin
                load_mul = 1'b1;
            end
            ST_MAP_LOAD: begin
                load_map_div = 1'b1;
            end
            ST_MAP_DIV: begin
                div_step = 1'b1;
            end
            ST_FINISH: begin
                load_val = 1'b1;
            end
            ST_OUTPUT: begin
                load_out = !m_valid || m_ready;
            end
            default: begin
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Outlier replacement and running window sum.
    always_comb begin
        if (s_distance_sample > SAMPLE_W'(OUTLIER_LIMIT)) begin
            sample_sel = win_reg[WINDOW_DEPTH-1];
        end else begin
            sample_sel = s_distance_sample[DIST_W-1:0];
        end
        sum_next = sum_reg - SUM_W'(win_reg[0]) + SUM_W'(sample_sel);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                win_reg[i] <= '0;
            end
            sum_reg <= '0;
        end else if (accept) begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WINDOW_DEPTH-1] <= sample_sel;
            sum_reg                 <= sum_next;
        end
    end

    // The rounded-up reciprocal of the depth gives the exact truncated mean
    // for every sum that fits in SUM_W bits.
    assign avg_prod = AVG_PROD_W'(sum_reg) * AVG_PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (accept) begin
            haptic_reg <= s_haptic_mode;
        end
        if (load_avg) begin
            avg_reg <= avg_prod[RECIP_SHIFT +: DIST_W];
        end
    end

    // Map operands: signed offset, signed output span and signed input span.
    always_comb begin
        out_lo    = direction_reg ? min_value_reg : max_value_reg;
        out_hi    = direction_reg ? max_value_reg : min_value_reg;
        diff_val  = $signed({1'b0, avg_reg}) - $signed({1'b0, min_distance_reg});
        span_val  = $signed({1'b0, out_hi}) - $signed({1'b0, out_lo});
        den_val   = $signed({1'b0, max_distance_reg}) - $signed({1'b0, min_distance_reg});
        den_zero  = (den_val == '0);
        prod_next = diff_val * span_val;
        prod_abs  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        den_abs   = den_val[DIFF_W-1] ? DIFF_W'(-den_val) : DIFF_W'(den_val);
    end

    always_ff @(posedge aclk) begin
        if (load_mul) begin
            prod_reg <= prod_next;
        end
        if (load_map_div) begin
            neg_reg <= prod_reg[PROD_W-1] ^ den_val[DIFF_W-1];
        end
    end

    // Restoring divider, one quotient bit per cycle.
    always_comb begin
        div_shift = {div_rem_reg, div_quo_reg[DIVIDEND_W-1]};
        div_diff  = div_shift - {1'b0, div_dvs_reg};
        div_ge    = !div_diff[DVS_W];
        div_last  = (div_cnt_reg == CNT_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (load_map_div) begin
            div_rem_reg <= '0;
            div_quo_reg <= prod_abs[MAG_W-1:0];
            div_dvs_reg <= den_abs[DIST_W-1:0];
            div_cnt_reg <= CNT_W'(DIVIDEND_W);
        end else if (div_step) begin
            div_rem_reg <= div_ge ? div_diff[DVS_W-1:0] : div_shift[DVS_W-1:0];
            div_quo_reg <= {div_quo_reg[DIVIDEND_W-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end
    end

    // Quotient sign, offset, clamp and haptic zeroing.
    always_comb begin
        if (den_zero) begin
            q_signed = '0;
        end else if (neg_reg) begin
            q_signed = -$signed({2'b00, div_quo_reg});
        end else begin
            q_signed = $signed({2'b00, div_quo_reg});
        end
        map_val = q_signed + $signed(VAL_W'(out_lo));
        lo_ext  = $signed(VAL_W'(min_value_reg));
        hi_ext  = $signed(VAL_W'(max_value_reg));
        if (map_val < lo_ext) begin
            clamp_val = min_value_reg;
        end else if (map_val > hi_ext) begin
            clamp_val = max_value_reg;
        end else begin
            clamp_val = map_val[VALUE_W-1:0];
        end
        if (haptic_reg && clamp_val <= min_value_reg) begin
            drive_next = '0;
        end else begin
            drive_next = clamp_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_val) begin
            val_reg <= drive_next;
        end
    end

    // Servo pulse count from the drive value.
    always_comb begin
        pulse_scaled = (PULSE_W + 1)'(val_reg) * (PULSE_W + 1)'(PULSE_NUM);
        if (haptic_reg) begin
            pulse_next = '0;
        end else begin
            pulse_next = PULSE_W'(pulse_scaled >> PULSE_SHIFT) + PULSE_LOW;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (load_out) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_average_distance <= avg_reg;
            m_drive_value      <= val_reg;
            m_servo_pulse      <= pulse_next;
            m_is_haptic        <= haptic_reg;
        end
    end

endmodule
`default_nettype wire

// ===== verif/drive_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_result_checker: result predictor and scoreboard for the servo drive
// Watches the register write port and both handshake channels of the block.
// Each accepted item is run through a cycle-free copy of the averaging window,
// linear map, clamp and pulse scaling, and the expected drive result is
// queued. Each result taken by the receiver is compared field by field with
// the oldest queued prediction. Mismatches and unexpected results raise the
// failure count that the testbench top reads for its verdict.
// ----------------------------------------------------------------------------
module drive_result_checker
    import dtsd_pkg::*;
(
    input  wire                   aclk,
    input  wire                   aresetn,

    input  wire                   cfg_we,
    input  wire [CFG_IDX_W-1:0]   cfg_index,
    input  wire [CFG_DATA_W-1:0]  cfg_wdata,

    input  wire                   s_valid,
    input  wire                   s_ready,
    input  wire [SAMPLE_W-1:0]    s_distance_sample,
    input  wire                   s_haptic_mode,

    input  wire                   m_valid,
    input  wire                   m_ready,
    input  wire [DIST_W-1:0]      m_average_distance,
    input  wire [VALUE_W-1:0]     m_drive_value,
    input  wire [PULSE_W-1:0]     m_servo_pulse,
    input  wire                   m_is_haptic,

    output int                    fail_count,
    output int                    pending_count,
    output int                    samples_taken,
    output int                    results_checked
);

    localparam int WIN_DEPTH     = 10;
    localparam int OUTLIER_LIMIT = 800;
    localparam int PULSE_SPAN    = 450;
    localparam int ANGLE_SPAN    = 180;

    typedef struct packed {
        logic [DIST_W-1:0]  average_distance;
        logic [VALUE_W-1:0] drive_value;
        logic [PULSE_W-1:0] servo_pulse;
        logic               is_haptic;
    } drive_result_t;

    logic [VALUE_W-1:0] value_min;
    logic [VALUE_W-1:0] value_max;
    logic [DIST_W-1:0]  dist_min;
    logic [DIST_W-1:0]  dist_max;
    logic               map_rising;

    logic [DIST_W-1:0]  win_samples [WIN_DEPTH];
    logic [13:0]        win_total;

    drive_result_t      expected_drive_q [$];

    function automatic drive_result_t absorb_sample(input logic [SAMPLE_W-1:0] raw,
                                                    input logic haptic);
        drive_result_t      r;
        logic [DIST_W-1:0]  kept;
        longint             mean;
        longint             x_lo;
        longint             x_hi;
        longint             y_lo;
        longint             y_hi;
        longint             lo;
        longint             hi;
        longint             val;
        longint             pulse;
        int                 i;

        // An outlier repeats the newest sample already in the window.
        kept = (raw > OUTLIER_LIMIT) ? win_samples[WIN_DEPTH-1] : raw[DIST_W-1:0];
        win_total = win_total - 14'(win_samples[0]) + 14'(kept);
        for (i = 0; i < WIN_DEPTH - 1; i++) begin
            win_samples[i] = win_samples[i+1];
        end
        win_samples[WIN_DEPTH-1] = kept;

        mean = longint'(win_total) / WIN_DEPTH;
        lo   = longint'(value_min);
        hi   = longint'(value_max);
        x_lo = longint'(dist_min);
        x_hi = longint'(dist_max);
        y_lo = map_rising ? lo : hi;
        y_hi = map_rising ? hi : lo;

        if (x_hi == x_lo) begin
            val = y_lo;
        end else begin
            val = (mean - x_lo) * (y_hi - y_lo) / (x_hi - x_lo) + y_lo;
        end

        if (val < lo) begin
            val = lo;
        end else if (val > hi) begin
            val = hi;
        end

        if (haptic) begin
            if (val < lo + 1) begin
                val = 0;
            end
            pulse = 0;
        end else begin
            pulse = val * PULSE_SPAN / ANGLE_SPAN + longint'(PULSE_LOW);
        end

        r.average_distance = mean[DIST_W-1:0];
        r.drive_value      = val[VALUE_W-1:0];
        r.servo_pulse      = pulse[PULSE_W-1:0];
        r.is_haptic        = haptic;
        return r;
    endfunction

    always @(posedge aclk) begin
        drive_result_t exp_r;

        if (!aresetn) begin
            value_min  = MIN_VALUE_RST;
            value_max  = MAX_VALUE_RST;
            dist_min   = MIN_DISTANCE_RST;
            dist_max   = MAX_DISTANCE_RST;
            map_rising = 1'b1;
            for (int i = 0; i < WIN_DEPTH; i++) begin
                win_samples[i] = '0;
            end
            win_total = '0;
            expected_drive_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MIN_VALUE:    value_min  = cfg_wdata[VALUE_W-1:0];
                    CFG_MAX_VALUE:    value_max  = cfg_wdata[VALUE_W-1:0];
                    CFG_MIN_DISTANCE: dist_min   = cfg_wdata[DIST_W-1:0];
                    CFG_MAX_DISTANCE: dist_max   = cfg_wdata[DIST_W-1:0];
                    CFG_DIRECTION:    map_rising = cfg_wdata[0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                expected_drive_q.push_back(absorb_sample(s_distance_sample, s_haptic_mode));
                samples_taken++;
            end

            if (m_valid && m_ready) begin
                if (expected_drive_q.size() == 0) begin
                    $error("Drive result with no sample waiting: avg %0d drive %0d pulse %0d",
                           m_average_distance, m_drive_value, m_servo_pulse);
                    fail_count++;
                end else begin
                    exp_r = expected_drive_q.pop_front();
                    results_checked++;
                    if (m_average_distance !== exp_r.average_distance) begin
                        $error("average_distance: expected %0d, actual %0d",
                               exp_r.average_distance, m_average_distance);
                        fail_count++;
                    end
                    if (m_drive_value !== exp_r.drive_value) begin
                        $error("drive_value: expected %0d, actual %0d",
                               exp_r.drive_value, m_drive_value);
                        fail_count++;
                    end
                    if (m_servo_pulse !== exp_r.servo_pulse) begin
                        $error("servo_pulse: expected %0d, actual %0d",
                               exp_r.servo_pulse, m_servo_pulse);
                        fail_count++;
                    end
                    if (m_is_haptic !== exp_r.is_haptic) begin
                        $error("is_haptic: expected %0d, actual %0d",
                               exp_r.is_haptic, m_is_haptic);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_drive_q.size();
    end

    initial begin
        fail_count      = 0;
        pending_count   = 0;
        samples_taken   = 0;
        results_checked = 0;
    end

endmodule

// ===== verif/tb_distance_to_servo_drive.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distance_to_servo_drive: testbench for the distance to servo drive block
// Drives distance items through the valid/ready input channel and takes the
// drive results with a randomly stalling receiver. A short directed part hits
// outliers on an empty window, field extremes, equal and reversed distance
// bounds, reversed value bounds and both modes. Random items then follow
// under many register settings and three idling patterns, while the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_distance_to_servo_drive;
    import dtsd_pkg::*;

    localparam int OUTLIER_LIMIT  = 800;
    localparam int ITEMS_PER_SET  = 80;
    localparam int SETS_PER_PHASE = 4;
    localparam int IDLE_PHASES    = 3;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic [SAMPLE_W-1:0]    s_distance_sample;
    logic                   s_haptic_mode;
    logic                   m_valid;
    logic                   m_ready;
    logic [DIST_W-1:0]      m_average_distance;
    logic [VALUE_W-1:0]     m_drive_value;
    logic [PULSE_W-1:0]     m_servo_pulse;
    logic                   m_is_haptic;

    int fail_count;
    int pending_count;
    int samples_taken;
    int results_checked;
    int send_idle_pct;
    int recv_idle_pct;
    int settings_used;
    int dist_a;
    int dist_b;

    distance_to_servo_drive uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_distance_sample  (s_distance_sample),
        .s_haptic_mode      (s_haptic_mode),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_average_distance (m_average_distance),
        .m_drive_value      (m_drive_value),
        .m_servo_pulse      (m_servo_pulse),
        .m_is_haptic        (m_is_haptic)
    );

    drive_result_checker checker_i (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_distance_sample  (s_distance_sample),
        .s_haptic_mode      (s_haptic_mode),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_average_distance (m_average_distance),
        .m_drive_value      (m_drive_value),
        .m_servo_pulse      (m_servo_pulse),
        .m_is_haptic        (m_is_haptic),
        .fail_count         (fail_count),
        .pending_count      (pending_count),
        .samples_taken      (samples_taken),
        .results_checked    (results_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d drive results still pending.", pending_count);
        $display("tb_distance_to_servo_drive NOT OK");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so that back-to-back items need no extra edge.
    task automatic push_sample(input logic [SAMPLE_W-1:0] sample, input logic haptic);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_distance_sample <= sample;
        s_haptic_mode     <= haptic;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_count != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_drive_config(input int vlo, input int vhi, input int dlo,
                                    input int dhi, input int rising);
        write_reg(CFG_MIN_VALUE, vlo);
        write_reg(CFG_MAX_VALUE, vhi);
        write_reg(CFG_MIN_DISTANCE, dlo);
        write_reg(CFG_MAX_DISTANCE, dhi);
        write_reg(CFG_DIRECTION, rising);
        dist_a = dlo;
        dist_b = dhi;
        settings_used++;
    endtask

    task automatic random_config(input bit extreme, input int rising);
        int vlo;
        int vhi;
        int dlo;
        int dhi;
        int t;

        if (extreme) begin
            set_drive_config(0, 180, 0, 800, rising);
        end else begin
            vlo = $urandom_range(180);
            vhi = $urandom_range(180);
            dlo = $urandom_range(800);
            dhi = $urandom_range(800);
            // Mostly well-ordered bounds, with some reversed ones left in.
            if ($urandom_range(9) < 8) begin
                if (vlo > vhi) begin
                    t = vlo; vlo = vhi; vhi = t;
                end
                if (dlo > dhi) begin
                    t = dlo; dlo = dhi; dhi = t;
                end
            end
            set_drive_config(vlo, vhi, dlo, dhi, $urandom_range(1));
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int pick;
        int lo_d;
        int hi_d;

        pick = $urandom_range(99);
        lo_d = (dist_a < dist_b) ? dist_a : dist_b;
        hi_d = (dist_a < dist_b) ? dist_b : dist_a;
        if (pick < 15) begin
            return SAMPLE_W'($urandom_range(16'hFFFF, OUTLIER_LIMIT + 1));
        end
        if (pick < 30) begin
            return SAMPLE_W'($urandom_range(OUTLIER_LIMIT));
        end
        // Most samples land around the configured distance span.
        lo_d = (lo_d > 60) ? lo_d - 60 : 0;
        hi_d = (hi_d + 60 > OUTLIER_LIMIT) ? OUTLIER_LIMIT : hi_d + 60;
        return SAMPLE_W'($urandom_range(hi_d, lo_d));
    endfunction

    initial begin
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_distance_sample = '0;
        s_haptic_mode     = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_MIN_VALUE;
        cfg_wdata         = '0;
        send_idle_pct     = 10;
        recv_idle_pct     = 72;
        settings_used     = 1;
        dist_a            = int'(MIN_DISTANCE_RST);
        dist_b            = int'(MAX_DISTANCE_RST);

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: outlier on an empty window, field extremes, clamp high.
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'd0, 1'b1);
        push_sample(16'd800, 1'b0);
        push_sample(16'd801, 1'b0);
        push_sample(16'd1023, 1'b1);
        push_sample(16'd1024, 1'b0);
        push_sample(16'h5555, 1'b0);
        push_sample(16'hAAAA, 1'b1);
        push_sample(16'd800, 1'b0);
        push_sample(16'd800, 1'b1);
        push_sample(16'd20, 1'b0);
        push_sample(16'd5, 1'b1);

        // Equal distance bounds, both map directions.
        settle();
        set_drive_config(40, 120, 100, 100, 1);
        push_sample(16'd300, 1'b0);
        push_sample(16'd0, 1'b1);
        settle();
        write_reg(CFG_DIRECTION, 0);
        push_sample(16'd100, 1'b0);

        // Value bounds out of order.
        settle();
        set_drive_config(150, 30, 0, 800, 1);
        push_sample(16'd0, 1'b0);
        push_sample(16'd800, 1'b0);
        push_sample(16'd400, 1'b1);

        // Distance bounds out of order, reversed map.
        settle();
        set_drive_config(0, 180, 600, 100, 0);
        push_sample(16'd700, 1'b0);
        push_sample(16'd100, 1'b1);
        push_sample(16'd350, 1'b0);
        push_sample(16'd800, 1'b1);

        for (int ph = 0; ph < IDLE_PHASES; ph++) begin
            case (ph)
                0: begin send_idle_pct = 10; recv_idle_pct = 72; end
                1: begin send_idle_pct = 72; recv_idle_pct = 10; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int k = 0; k < SETS_PER_PHASE; k++) begin
                settle();
                random_config(k == 0, ph % 2);
                repeat (ITEMS_PER_SET) push_sample(random_sample(), 1'($urandom_range(1)));
            end
        end

        settle();
        repeat (100) @(negedge aclk);

        $display("Checked %0d drive results from %0d accepted items under %0d settings,",
                 results_checked, samples_taken, settings_used);
        $display("with sender and receiver stalls in three idling patterns.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_distance_to_servo_drive OK");
        end else begin
            $display("tb_distance_to_servo_drive NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dtsd_pkg.sv
design/distance_to_servo_drive.sv
verif/drive_result_checker.sv
verif/tb_distance_to_servo_drive.sv
